// File: rtl/core/ibh_pkg.sv
// Shared types, codes and constants of the indexed binary heap.
package ibh_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int HANDLE_W      = 10;
    localparam int TOTAL_W       = 11;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT,
        OP_UPDATE,
        OP_ERASE,
        OP_POP
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_NOT_FOUND,
        ST_FULL,
        ST_PRESENT
    } t_status;

    // One step of work, issued by the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_CLEAR,
        CMD_LOAD,
        CMD_LOOK,
        CMD_CHECK,
        CMD_KEYS,
        CMD_UP_RD,
        CMD_UP_KEY,
        CMD_UP_CMP,
        CMD_DN_RD,
        CMD_DN_KEY,
        CMD_DN_CMP,
        CMD_PLACE,
        CMD_RESPOND
    } t_cmd;

    // Where the operation goes after its first check.
    typedef enum logic [1:0] {
        RT_DONE,
        RT_KEYS,
        RT_UP
    } t_route;

    typedef struct packed {
        t_route route;
        logic   fetch_done;
        logic   hole_top;
        logic   no_left;
        logic   moved;
        logic   up_only;
        logic   clear_last;
        logic   out_busy;
    } t_dp_stat;

endpackage

// File: rtl/core/ibh_ctrl.sv
// Controller state machine of the indexed binary heap.
module ibh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ibh_pkg::t_dp_stat i_stat,
    output logic             o_in_ready,
    output ibh_pkg::t_cmd    o_cmd
);
    import ibh_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_KEYS,
        S_UP_RD,
        S_UP_KEY,
        S_UP_CMP,
        S_DN_RD,
        S_DN_KEY,
        S_DN_CMP,
        S_PLACE,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_LOAD;
        case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd = CMD_LOAD;
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                o_cmd   = CMD_LOOK;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd = CMD_CHECK;
                case (i_stat.route)
                    RT_KEYS: n_state = S_KEYS;
                    RT_UP:   n_state = S_UP_RD;
                    default: n_state = S_RESP;
                endcase
            end
            S_KEYS: begin
                o_cmd   = CMD_KEYS;
                n_state = i_stat.fetch_done ? S_RESP : S_UP_RD;
            end
            S_UP_RD: begin
                o_cmd = CMD_UP_RD;
                if (!i_stat.hole_top) n_state = S_UP_KEY;
                else if (i_stat.up_only) n_state = S_PLACE;
                else n_state = S_DN_RD;
            end
            S_UP_KEY: begin
                o_cmd   = CMD_UP_KEY;
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                o_cmd = CMD_UP_CMP;
                if (i_stat.moved) n_state = S_UP_RD;
                else if (i_stat.up_only) n_state = S_PLACE;
                else n_state = S_DN_RD;
            end
            S_DN_RD: begin
                o_cmd   = CMD_DN_RD;
                n_state = i_stat.no_left ? S_PLACE : S_DN_KEY;
            end
            S_DN_KEY: begin
                o_cmd   = CMD_DN_KEY;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd   = CMD_DN_CMP;
                n_state = i_stat.moved ? S_DN_RD : S_PLACE;
            end
            S_PLACE: begin
                o_cmd   = CMD_PLACE;
                n_state = S_RESP;
            end
            S_RESP: begin
                o_cmd = CMD_RESPOND;
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: begin
                o_cmd   = CMD_LOAD;
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/core/ibh_dp.sv
// Datapath of the indexed binary heap: stores, read registers and the moving entry.
module ibh_dp #(
    parameter int CAPACITY  = ibh_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ibh_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ibh_pkg::t_cmd                 i_cmd,
    input  logic                          i_in_valid,
    input  ibh_pkg::t_op                  i_op,
    input  logic [ibh_pkg::HANDLE_W-1:0]  i_handle,
    input  logic [KEY_WIDTH-1:0]          i_key,
    input  logic                          i_heap_is_max,
    input  logic                          i_out_ready,
    output ibh_pkg::t_dp_stat             o_stat,
    output logic                          o_out_valid,
    output ibh_pkg::t_status              o_status,
    output logic [ibh_pkg::HANDLE_W-1:0]  o_handle,
    output logic [KEY_WIDTH-1:0]          o_key,
    output logic [ibh_pkg::TOTAL_W-1:0]   o_total
);
    import ibh_pkg::*;

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = PW + 2;

    // Stores: heap slots, handle positions, handle keys, presence bits.
    logic [PW-1:0]        r_tree [CAPACITY];
    logic [PW-1:0]        r_hpos [CAPACITY];
    logic [KEY_WIDTH-1:0] r_hkey [CAPACITY];
    logic                 r_pres [CAPACITY];

    logic [PW-1:0]        r_ta_q, r_tb_q, r_pos_q;
    logic [KEY_WIDTH-1:0] r_ka_q, r_kb_q;
    logic                 r_pres_q;

    t_op                  r_op;
    logic [PW-1:0]        r_hidx;
    logic                 r_hbad;
    logic [KEY_WIDTH-1:0] r_key_in;
    logic [CW-1:0]        r_cnt;
    logic [PW-1:0]        r_hole, r_par, r_left, r_right;
    logic                 r_right_ok;
    logic [PW-1:0]        r_cur_h, r_nb_h, r_rb_h;
    logic [KEY_WIDTH-1:0] r_cur_k;
    t_status              r_stat;
    logic [PW-1:0]        r_out_h;
    logic [KEY_WIDTH-1:0] r_out_k;
    logic [PW-1:0]        r_clr;
    logic                 r_ov;
    t_status              r_o_status;
    logic [HANDLE_W-1:0]  r_o_h;
    logic [KEY_WIDTH-1:0] r_o_k;
    logic [TOTAL_W-1:0]   r_o_total;

    logic [PW-1:0]        ta_addr, tb_addr, ka_addr, kb_addr;
    logic                 tree_we, hpos_we, hkey_we, pres_we;
    logic [PW-1:0]        tree_wa, tree_wd, hpos_wa, hpos_wd, hkey_wa, pres_wa;
    logic [KEY_WIDTH-1:0] hkey_wd;
    logic                 pres_wd;

    logic [PW-1:0]        parent;
    logic [LW-1:0]        left, right;
    logic [CW-1:0]        cnt_m1;
    logic                 up_move, l_better, r_better;
    logic [KEY_WIDTH-1:0] best_k;
    logic [PW-1:0]        best_h, best_pos;
    logic                 ok_pop, ok_ins, ok_upd, ok_era, era_tail;
    t_status              chk_status;
    t_route               route;
    logic                 out_busy;

    // True when key a must sit above key b in the current order.
    function automatic logic above(input logic [KEY_WIDTH-1:0] a,
                                   input logic [KEY_WIDTH-1:0] b,
                                   input logic                 is_max);
        above = is_max ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    endfunction

    always_comb begin
        parent   = (r_hole - PW'(1)) >> 1;
        left     = (LW'(r_hole) << 1) + LW'(1);
        right    = left + LW'(1);
        cnt_m1   = r_cnt - CW'(1);
        up_move  = above(r_cur_k, r_ka_q, i_heap_is_max);
        l_better = above(r_ka_q, r_cur_k, i_heap_is_max);
        best_k   = l_better ? r_ka_q : r_cur_k;
        r_better = r_right_ok && above(r_kb_q, best_k, i_heap_is_max);
        best_h   = r_better ? r_rb_h : r_nb_h;
        best_pos = r_better ? r_right : r_left;

        ok_pop   = (r_op == OP_POP) && (r_cnt != '0);
        ok_ins   = (r_op == OP_INSERT) && !r_hbad && !r_pres_q && (r_cnt != CW'(CAPACITY));
        ok_upd   = (r_op == OP_UPDATE) && !r_hbad && r_pres_q;
        ok_era   = (r_op == OP_ERASE) && !r_hbad && r_pres_q;
        era_tail = (CW'(r_pos_q) == cnt_m1);

        if (r_op == OP_POP) begin
            chk_status = (r_cnt == '0) ? ST_EMPTY : ST_OK;
        end else if (r_hbad) begin
            chk_status = ST_NOT_FOUND;
        end else if (r_op == OP_INSERT) begin
            if (r_pres_q) chk_status = ST_PRESENT;
            else if (r_cnt == CW'(CAPACITY)) chk_status = ST_FULL;
            else chk_status = ST_OK;
        end else begin
            chk_status = r_pres_q ? ST_OK : ST_NOT_FOUND;
        end

        if (ok_pop || (ok_era && !era_tail)) route = RT_KEYS;
        else if (ok_ins || ok_upd) route = RT_UP;
        else route = RT_DONE;

        ta_addr = '0;
        tb_addr = '0;
        ka_addr = '0;
        kb_addr = '0;
        tree_we = 1'b0;
        tree_wa = r_hole;
        tree_wd = r_cur_h;
        hpos_we = 1'b0;
        hpos_wa = r_cur_h;
        hpos_wd = r_hole;
        hkey_we = 1'b0;
        hkey_wa = r_hidx;
        hkey_wd = r_key_in;
        pres_we = 1'b0;
        pres_wa = r_hidx;
        pres_wd = 1'b0;

        case (i_cmd)
            CMD_CLEAR: begin
                pres_we = 1'b1;
                pres_wa = r_clr;
            end
            CMD_LOOK: begin
                tb_addr = PW'(cnt_m1);
            end
            CMD_CHECK: begin
                ka_addr = r_ta_q;
                kb_addr = r_tb_q;
                if (ok_ins || ok_upd) hkey_we = 1'b1;
                if (ok_ins) begin
                    pres_we = 1'b1;
                    pres_wd = 1'b1;
                end
                if (ok_era) pres_we = 1'b1;
                if (ok_pop) begin
                    pres_we = 1'b1;
                    pres_wa = r_ta_q;
                end
            end
            CMD_UP_RD: begin
                ta_addr = parent;
            end
            CMD_UP_KEY: begin
                ka_addr = r_ta_q;
            end
            CMD_UP_CMP: begin
                if (up_move) begin
                    tree_we = 1'b1;
                    tree_wd = r_nb_h;
                    hpos_we = 1'b1;
                    hpos_wa = r_nb_h;
                end
            end
            CMD_DN_RD: begin
                ta_addr = PW'(left);
                tb_addr = PW'(right);
            end
            CMD_DN_KEY: begin
                ka_addr = r_ta_q;
                kb_addr = r_tb_q;
            end
            CMD_DN_CMP: begin
                if (l_better || r_better) begin
                    tree_we = 1'b1;
                    tree_wd = best_h;
                    hpos_we = 1'b1;
                    hpos_wa = best_h;
                end
            end
            CMD_PLACE: begin
                tree_we = 1'b1;
                hpos_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign out_busy = r_ov && !i_out_ready;

    always_comb begin
        o_stat.route      = route;
        o_stat.fetch_done = (r_op == OP_POP) && (r_cnt == '0);
        o_stat.hole_top   = (r_hole == '0);
        o_stat.no_left    = (left >= LW'(r_cnt));
        o_stat.moved      = (i_cmd == CMD_UP_CMP) ? up_move : (l_better || r_better);
        // An insert only climbs; it never sifts down afterwards.
        o_stat.up_only    = (r_op == OP_INSERT);
        o_stat.clear_last = (r_clr == PW'(CAPACITY - 1));
        o_stat.out_busy   = out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (tree_we) r_tree[tree_wa] <= tree_wd;
        r_ta_q <= r_tree[ta_addr];
        r_tb_q <= r_tree[tb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (hpos_we) r_hpos[hpos_wa] <= hpos_wd;
        r_pos_q <= r_hpos[r_hidx];
    end

    always_ff @(posedge i_clk) begin
        if (hkey_we) r_hkey[hkey_wa] <= hkey_wd;
        r_ka_q <= r_hkey[ka_addr];
        r_kb_q <= r_hkey[kb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pres_we) r_pres[pres_wa] <= pres_wd;
        r_pres_q <= r_pres[r_hidx];
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_clr <= '0;
            r_ov  <= 1'b0;
        end else begin
            case (i_cmd)
                CMD_CLEAR: begin
                    r_clr <= r_clr + PW'(1);
                end
                CMD_LOAD: begin
                    if (i_in_valid) begin
                        r_op     <= i_op;
                        r_hidx   <= PW'(i_handle);
                        r_hbad   <= (32'(i_handle) >= 32'(CAPACITY));
                        r_key_in <= i_key;
                        r_out_h  <= '0;
                        r_out_k  <= '0;
                    end
                end
                CMD_CHECK: begin
                    r_stat <= chk_status;
                    if (ok_pop) begin
                        r_out_h <= r_ta_q;
                        r_cur_h <= r_tb_q;
                        r_hole  <= '0;
                        r_cnt   <= cnt_m1;
                    end
                    if (ok_ins) begin
                        r_cur_h <= r_hidx;
                        r_cur_k <= r_key_in;
                        r_hole  <= PW'(r_cnt);
                        r_cnt   <= r_cnt + CW'(1);
                    end
                    if (ok_upd) begin
                        r_cur_h <= r_hidx;
                        r_cur_k <= r_key_in;
                        r_hole  <= r_pos_q;
                    end
                    if (ok_era) begin
                        r_cur_h <= r_tb_q;
                        r_hole  <= r_pos_q;
                        r_cnt   <= cnt_m1;
                    end
                end
                CMD_KEYS: begin
                    if (r_op == OP_POP) r_out_k <= r_ka_q;
                    r_cur_k <= r_kb_q;
                end
                CMD_UP_RD: begin
                    r_par <= parent;
                end
                CMD_UP_KEY: begin
                    r_nb_h <= r_ta_q;
                end
                CMD_UP_CMP: begin
                    if (up_move) r_hole <= r_par;
                end
                CMD_DN_RD: begin
                    r_left     <= PW'(left);
                    r_right    <= PW'(right);
                    r_right_ok <= (right < LW'(r_cnt));
                end
                CMD_DN_KEY: begin
                    r_nb_h <= r_ta_q;
                    r_rb_h <= r_tb_q;
                end
                CMD_DN_CMP: begin
                    if (l_better || r_better) r_hole <= best_pos;
                end
                default: begin
                end
            endcase

            if (i_cmd == CMD_RESPOND && !out_busy) begin
                r_ov       <= 1'b1;
                r_o_status <= r_stat;
                r_o_h      <= HANDLE_W'(r_out_h);
                r_o_k      <= r_out_k;
                r_o_total  <= TOTAL_W'(r_cnt);
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_o_status;
    assign o_handle    = r_o_h;
    assign o_key       = r_o_k;
    assign o_total     = r_o_total;

endmodule

// File: rtl/core/indexed_binary_heap.sv
// Top level of the indexed binary heap: stream ports, mode register and checks.
//
//  Channel   Direction  Moves                    Word layout (lowest bit first)
//  s_axis    in         one operation per word   tuser: op; tdata: handle, key_value
//  m_axis    out        one result per operation tuser: status; tdata: out_handle,
//                                                out_key, entry_total
//  cfg       in         heap_is_max write        i_cfg_wr_data: heap_is_max
//
// One operation is handled at a time. An operation passes through the idle state in which
// it is taken, a look-up and a check. A failed one, or an erase of the last entry, then goes
// straight to the response; any other may fetch keys first and then moves its entry level by
// level, each level costing a registered slot read, a registered key read and a compare,
// before the entry is placed and the result is given.
// After reset the presence bits are cleared one per cycle while s_axis_tready stays
// low. A stalled result sits in the output register; the next operation is taken
// meanwhile but cannot finish until that result is taken.
module indexed_binary_heap #(
    parameter int CAPACITY  = ibh_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ibh_pkg::KEY_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // handle [9:0], key_value above it, zero padding to whole bytes
    input  logic [((ibh_pkg::HANDLE_W + KEY_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // op [1:0]
    input  logic [ibh_pkg::OP_W-1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_handle [9:0], out_key above it, then entry_total, zero padding
    output logic [((ibh_pkg::HANDLE_W + KEY_WIDTH + ibh_pkg::TOTAL_W + 7) / 8) * 8 - 1:0]
                 m_axis_tdata,
    // status [2:0]
    output logic [ibh_pkg::STATUS_W-1:0] m_axis_tuser,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data
);
    import ibh_pkg::*;

    localparam int OUT_DW = ((HANDLE_W + KEY_WIDTH + TOTAL_W + 7) / 8) * 8;

    logic                 r_heap_is_max;
    t_cmd                 cmd;
    t_dp_stat             dp_stat;
    t_status              out_status;
    logic [HANDLE_W-1:0]  out_handle;
    logic [KEY_WIDTH-1:0] out_key;
    logic [TOTAL_W-1:0]   out_total;

    // Mode register; the user must write it only while no operation is in flight; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_is_max <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_heap_is_max <= i_cfg_wr_data;
        end
    end

    ibh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (dp_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    ibh_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_valid    (s_axis_tvalid),
        .i_op          (t_op'(s_axis_tuser)),
        .i_handle      (s_axis_tdata[HANDLE_W-1:0]),
        .i_key         (s_axis_tdata[HANDLE_W+KEY_WIDTH-1:HANDLE_W]),
        .i_heap_is_max (r_heap_is_max),
        .i_out_ready   (m_axis_tready),
        .o_stat        (dp_stat),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (out_status),
        .o_handle      (out_handle),
        .o_key         (out_key),
        .o_total       (out_total)
    );

    assign m_axis_tdata = OUT_DW'({out_total, out_key, out_handle});
    assign m_axis_tuser = out_status;

    // Only one operation is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("operation taken while another was in flight");

    // An empty pop must report an empty heap.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |->
        (m_axis_tdata[HANDLE_W+KEY_WIDTH+TOTAL_W-1:HANDLE_W+KEY_WIDTH] == '0))
        else $error("empty status with non-zero entry count");

    // A full report means the count sits at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FULL) |->
        (m_axis_tdata[HANDLE_W+KEY_WIDTH+TOTAL_W-1:HANDLE_W+KEY_WIDTH] ==
         TOTAL_W'(CAPACITY)))
        else $error("full status below capacity");

    // A failed operation returns no handle or key.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |->
        (m_axis_tdata[HANDLE_W+KEY_WIDTH-1:0] == '0))
        else $error("failed operation returned data");

endmodule
